// ===== sv/plgs_pkg.sv =====
package plgs_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int CW           = 36;
  localparam int ANGLE_W      = 32;
  localparam int HEAD_W       = 16;
  localparam int LEN_W        = 32;
  localparam int DIST_W       = 31;
  localparam int STEP_IDX_W   = 5;
  localparam int ATAN_LEN     = 30;
  localparam int GAIN_W       = 30;

  localparam logic [GAIN_W-1:0]  INV_GAIN      = 30'd652032874;
  localparam logic [DIST_W-1:0]  DIST_RESET    = 31'd131072;
  localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 32'hC000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] pose_x;
    logic signed [COORD_W-1:0] pose_y;
    logic                      last_pose;
  } in_item_t;

  typedef struct packed {
    logic                      goal_found;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [HEAD_W-1:0]  goal_heading;
    logic [LEN_W-1:0]          arc_length;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANGLE_W-1:0]   z;
  } cell_t;

  typedef struct packed {
    logic              vld;
    logic [LEN_W-1:0]  len;
    logic [HEAD_W-1:0] heading;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAIT,
    ST_FIN
  } state_t;

  // Arctangent of 2^-i with 2^32 as a full turn; steps past the table add nothing.
  function automatic logic [ANGLE_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2E;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000028;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000002;
      5'd29:   a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/plgs_cell.sv =====
module plgs_cell
  import plgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [STEP_IDX_W-1:0] step_idx,
  input  cell_t                 d_in,
  output cell_t                 d_out
);

  cell_t d_out_nxt;
  cell_t d_out_r;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [ANGLE_W-1:0]   a;

  always_comb begin
    xs = d_in.x >>> step_idx;
    ys = d_in.y >>> step_idx;
    a  = atan_entry(step_idx);
    d_out_nxt.vld = d_in.vld;
    // A positive y turns the vector clockwise.
    if (d_in.y > 0) begin
      d_out_nxt.x = d_in.x + ys;
      d_out_nxt.y = d_in.y - xs;
      d_out_nxt.z = d_in.z + a;
    end else begin
      d_out_nxt.x = d_in.x - ys;
      d_out_nxt.y = d_in.y + xs;
      d_out_nxt.z = d_in.z - a;
    end
  end

  always_ff @(posedge clk) begin
    d_out_r.x <= d_out_nxt.x;
    d_out_r.y <= d_out_nxt.y;
    d_out_r.z <= d_out_nxt.z;
    if (!rst_n) begin
      d_out_r.vld <= 1'b0;
    end else begin
      d_out_r.vld <= d_out_nxt.vld;
    end
  end

  assign d_out = d_out_r;

endmodule

// ===== sv/plgs_cordic_chain.sv =====
module plgs_cordic_chain
  import plgs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output cell_t                    result
);

  cell_t stage [CORDIC_STEPS+1];
  cell_t head;

  logic signed [CW-1:0] ex;
  logic signed [CW-1:0] ey;

  // Vectors in the left half plane are first turned by a quarter turn.
  always_comb begin
    ex = CW'(dx);
    ey = CW'(dy);
    head.vld = start;
    if (ex < 0) begin
      if (ey >= 0) begin
        head.x = ey;
        head.y = -ex;
        head.z = ANGLE_QUARTER;
      end else begin
        head.x = -ey;
        head.y = ex;
        head.z = ANGLE_3QUART;
      end
    end else begin
      head.x = ex;
      head.y = ey;
      head.z = '0;
    end
  end

  assign stage[0] = head;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    plgs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_IDX_W'(i)),
      .d_in     (stage[i]),
      .d_out    (stage[i+1])
    );
  end

  assign result = stage[CORDIC_STEPS];

endmodule

// ===== sv/plgs_scale.sv =====
module plgs_scale
  import plgs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cell_t d_in,
  output seg_t  seg
);

  localparam int XL_W   = 18;
  localparam int XH_W   = CW - XL_W;
  localparam int PL_W   = XL_W + GAIN_W;
  localparam int PH_W   = XH_W + GAIN_W;
  localparam int PROD_W = CW + GAIN_W + 1;
  localparam int Q_W    = PROD_W - GAIN_W;
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (GAIN_W - 1);

  logic [XL_W-1:0]   xl;
  logic [XH_W-1:0]   xh;
  logic [PL_W-1:0]   pl_nxt, pl_r;
  logic [PH_W-1:0]   ph_nxt, ph_r;
  logic [ANGLE_W-1:0] zr;
  logic [HEAD_W-1:0] h1_nxt, h1_r;
  logic              pos_nxt, pos_r;
  logic              v1_r, v2_r;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  logic [LEN_W-1:0]  len_nxt, len_r;
  logic [HEAD_W-1:0] h2_r;

  // The gain product is split in two partial products to keep each multiplier small.
  always_comb begin
    xl      = d_in.x[XL_W-1:0];
    xh      = d_in.x[CW-1:XL_W];
    pos_nxt = d_in.x > 0;
    pl_nxt  = PL_W'(xl) * PL_W'(INV_GAIN);
    ph_nxt  = PH_W'(xh) * PH_W'(INV_GAIN);
    zr      = d_in.z + ANGLE_W'(32'h0000_8000);
    h1_nxt  = zr[ANGLE_W-1:ANGLE_W-HEAD_W];
  end

  always_comb begin
    prod = (PROD_W'(ph_r) << XL_W) + PROD_W'(pl_r) + ROUND_BIAS;
    q    = prod[PROD_W-1:GAIN_W];
    if (!pos_r) begin
      len_nxt = '0;
    end else if (|q[Q_W-1:LEN_W]) begin
      len_nxt = '1;
    end else begin
      len_nxt = q[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= d_in.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pl_r  <= pl_nxt;
    ph_r  <= ph_nxt;
    pos_r <= pos_nxt;
    h1_r  <= h1_nxt;
    len_r <= len_nxt;
    h2_r  <= h1_r;
  end

  assign seg.vld     = v2_r;
  assign seg.len     = len_r;
  assign seg.heading = h2_r;

endmodule

// ===== sv/path_lookahead_goal_select.sv =====
// Lookahead goal selection on a path of poses. Each pose after the first of a
// path forms a segment with the previous one; a row of CORDIC vectoring cells,
// one rotation step per cell per cycle, gives its length and heading, and the
// lengths are summed with saturation. The goal is the first pose at which the
// sum reaches the lookahead distance, or else the final pose; one result is
// sent on the pose that carries last_pose. Poses are taken one at a time: a
// pose that forms a segment occupies the block until it has passed the cell
// row and the two gain multiply stages; any other pose goes straight to the
// finish state. A new pose is accepted while an earlier result still waits
// on the output; a final pose stalls only if that result has not yet been
// taken. Configuration writes are always ready.
module path_lookahead_goal_select
  import plgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DIST_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [DIST_W-1:0]        lookahead_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_W-1:0] chosen_x_r, chosen_y_r;
  logic [HEAD_W-1:0]        chosen_h_r;
  logic [LEN_W-1:0]         length_sum_r;
  logic                     have_prev_r, target_r;
  logic                     found_r, last_r, zero_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic  accept, seg_needed, chain_start, emit, out_busy;
  cell_t chain_out;
  seg_t  seg;

  logic [LEN_W:0]    sum_wide;
  logic [LEN_W-1:0]  sum_sat;
  logic [LEN_W-1:0]  seg_len;
  logic [HEAD_W-1:0] seg_head;

  assign cfg_ready = 1'b1;

  plgs_cordic_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (chain_start),
    .dx     (dx_r),
    .dy     (dy_r),
    .result (chain_out)
  );

  plgs_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (chain_out),
    .seg   (seg)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = seg_needed ? ST_PREP : ST_FIN;
        end
      end
      ST_PREP: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (seg.vld) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r || !out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_busy    = out_valid_r && out_stall;
    seg_needed  = have_prev_r && !target_r;
    in_stall    = state_r != ST_IDLE;
    accept      = in_valid && (state_r == ST_IDLE);
    chain_start = state_r == ST_PREP;
    emit        = (state_r == ST_FIN) && last_r && !out_busy;
  end

  // A zero-length segment reads as length zero and heading zero.
  always_comb begin
    seg_len  = zero_r ? '0 : seg.len;
    seg_head = zero_r ? '0 : seg.heading;
    sum_wide = {1'b0, length_sum_r} + {1'b0, seg_len};
    sum_sat  = sum_wide[LEN_W] ? '1 : sum_wide[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lookahead_r  <= DIST_RESET;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      chosen_x_r   <= '0;
      chosen_y_r   <= '0;
      chosen_h_r   <= '0;
      length_sum_r <= '0;
      have_prev_r  <= 1'b0;
      target_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        lookahead_r <= cfg_data;
      end
      if (accept && !target_r) begin
        prev_x_r    <= in_data.pose_x;
        prev_y_r    <= in_data.pose_y;
        have_prev_r <= 1'b1;
        if (have_prev_r) begin
          chosen_x_r <= in_data.pose_x;
          chosen_y_r <= in_data.pose_y;
        end
      end
      if (state_r == ST_WAIT && seg.vld) begin
        length_sum_r <= sum_sat;
        chosen_h_r   <= seg_head;
        if (sum_sat >= {1'b0, lookahead_r}) begin
          target_r <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_r  <= 1'b1;
        have_prev_r  <= 1'b0;
        target_r     <= 1'b0;
        length_sum_r <= '0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= have_prev_r;
      last_r  <= in_data.last_pose;
      dx_r    <= DIFF_W'(in_data.pose_x) - DIFF_W'(prev_x_r);
      dy_r    <= DIFF_W'(in_data.pose_y) - DIFF_W'(prev_y_r);
    end
    if (state_r == ST_PREP) begin
      zero_r <= (dx_r == '0) && (dy_r == '0);
    end
    if (emit) begin
      if (found_r) begin
        out_data_r.goal_found   <= 1'b1;
        out_data_r.goal_x       <= chosen_x_r;
        out_data_r.goal_y       <= chosen_y_r;
        out_data_r.goal_heading <= chosen_h_r;
        out_data_r.arc_length   <= length_sum_r;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
